>>> rtl/rfde_pkg.sv
// Shared types, constants and colour packing for the RGB565 draw engine.
`timescale 1ns / 1ps

package rfde_pkg;

   localparam int DEF_WIDTH  = 320;
   localparam int DEF_HEIGHT = 240;

   localparam int COORD_W = 10;
   localparam int COLOR_W = 16;
   localparam int SIZE_W  = 4;
   localparam int CHAN_W  = 8;

   localparam logic [COLOR_W-1:0] BOX_COLOR_RESET = 16'hE0FF;

   localparam logic [1:0] CMD_PIXEL = 2'd0;
   localparam logic [1:0] CMD_FILL  = 2'd1;
   localparam logic [1:0] CMD_BOX   = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] y0;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y1;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [COLOR_W-1:0] fill_color;
      logic [SIZE_W-1:0]  size;
   } req_type;

   typedef struct packed {
      logic               valid;
      logic               status;
      logic [COLOR_W-1:0] pixel;
   } rsp_type;

   // Keep the top bits of each channel: 5 red, 6 green, 5 blue.
   function automatic logic [COLOR_W-1:0] pack565(input logic [CHAN_W-1:0] r,
                                                  input logic [CHAN_W-1:0] g,
                                                  input logic [CHAN_W-1:0] b);
      pack565 = {r[7:3], g[7:2], b[7:3]};
   endfunction

endpackage

>>> rtl/rfde_frame_ram.sv
// Single-port frame store with registered read data.
`timescale 1ns / 1ps

module rfde_frame_ram
   import rfde_pkg::*;
#(
   parameter int DEPTH  = DEF_WIDTH * DEF_HEIGHT,
   parameter int ADDR_W = $clog2(DEF_WIDTH * DEF_HEIGHT)
) (
   input  logic               clock,
   input  logic               we,
   input  logic               re,
   input  logic [ADDR_W-1:0]  addr,
   input  logic [COLOR_W-1:0] wdata,
   output logic [COLOR_W-1:0] rdata
);

   logic [COLOR_W-1:0] mem [DEPTH];
   logic [COLOR_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/rfde_draw_seq.sv
// Command sequencer: range checks, pixel walk for squares and outlines, read-back.
`timescale 1ns / 1ps

module rfde_draw_seq
   import rfde_pkg::*;
#(
   parameter int WIDTH  = DEF_WIDTH,
   parameter int HEIGHT = DEF_HEIGHT,
   parameter int ADDR_W = $clog2(DEF_WIDTH * DEF_HEIGHT)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  req_type            req,
   input  logic [COLOR_W-1:0] box_color,
   output logic               busy,
   output logic               ram_we,
   output logic               ram_re,
   output logic [ADDR_W-1:0]  ram_addr,
   output logic [COLOR_W-1:0] ram_wdata,
   input  logic [COLOR_W-1:0] ram_rdata,
   output rsp_type            rsp
);

   localparam int CX_W   = COORD_W + 1;
   localparam int PROD_W = 2 * COORD_W;

   localparam logic [COORD_W-1:0] W_C   = COORD_W'(WIDTH);
   localparam logic [COORD_W-1:0] H_C   = COORD_W'(HEIGHT);
   localparam logic [CX_W-1:0]    W_EXT = CX_W'(WIDTH);
   localparam logic [CX_W-1:0]    H_EXT = CX_W'(HEIGHT);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_FILL    = 3'd1;
   localparam logic [2:0] S_BOX     = 3'd2;
   localparam logic [2:0] S_RD_WAIT = 3'd3;
   localparam logic [2:0] S_RD_DONE = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [COORD_W-1:0] bx_ff, bx_in, by_ff, by_in, ex_ff, ex_in, ey_ff, ey_in;
   logic [COLOR_W-1:0] fc_ff, fc_in;
   logic [SIZE_W-1:0]  size_ff, size_in, i_ff, i_in, j_ff, j_in;
   logic [1:0]         phase_ff, phase_in;
   logic [COORD_W-1:0] cnt_ff, cnt_in;

   logic               op_we_ff, op_we_in, op_re_ff, op_re_in;
   logic [COORD_W-1:0] op_x_ff, op_x_in, op_y_ff, op_y_in;
   logic [COLOR_W-1:0] op_color_ff, op_color_in;

   logic               rsp_valid_ff, rsp_valid_in, rsp_status_ff, rsp_status_in;
   logic [COLOR_W-1:0] rsp_pixel_ff, rsp_pixel_in;

   logic               in_frame, fill_bad, box_bad, box_last;
   logic [SIZE_W-1:0]  size_last;
   logic [PROD_W-1:0]  lin;

   assign in_frame = (req.x0 < W_C) && (req.y0 < H_C);
   assign fill_bad = (({1'b0, req.x0} + CX_W'(req.size)) > W_EXT) ||
                     (({1'b0, req.y0} + CX_W'(req.size)) > H_EXT);
   assign box_bad  = (req.x0 >= W_C) || (req.x1 >= W_C) || (req.y0 >= H_C) ||
                     (req.y1 >= H_C) || (req.x0 > req.x1) || (req.y0 > req.y1);

   assign size_last = size_ff - SIZE_W'(1);
   assign box_last  = (cnt_ff == (phase_ff[1] ? ey_ff : ex_ff));

   always_comb begin
      state_in      = state_ff;
      bx_in         = bx_ff;
      by_in         = by_ff;
      ex_in         = ex_ff;
      ey_in         = ey_ff;
      fc_in         = fc_ff;
      size_in       = size_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      op_we_in      = 1'b0;
      op_re_in      = 1'b0;
      op_x_in       = op_x_ff;
      op_y_in       = op_y_ff;
      op_color_in   = op_color_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_pixel_in  = rsp_pixel_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req.cmd)
                  CMD_PIXEL: begin
                     op_we_in      = in_frame;
                     op_x_in       = req.x0;
                     op_y_in       = req.y0;
                     op_color_in   = pack565(req.red, req.green, req.blue);
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = !in_frame;
                     rsp_pixel_in  = '0;
                  end
                  CMD_FILL: begin
                     bx_in   = req.x0;
                     by_in   = req.y0;
                     fc_in   = req.fill_color;
                     size_in = req.size;
                     i_in    = '0;
                     j_in    = '0;
                     if (fill_bad || (req.size == '0)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = fill_bad;
                        rsp_pixel_in  = '0;
                     end else begin
                        state_in = S_FILL;
                     end
                  end
                  CMD_BOX: begin
                     bx_in    = req.x0;
                     by_in    = req.y0;
                     ex_in    = req.x1;
                     ey_in    = req.y1;
                     phase_in = 2'd0;
                     cnt_in   = req.x0;
                     if (box_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = 1'b1;
                        rsp_pixel_in  = '0;
                     end else begin
                        state_in = S_BOX;
                     end
                  end
                  CMD_READ: begin
                     op_x_in = req.x0;
                     op_y_in = req.y0;
                     if (in_frame) begin
                        op_re_in = 1'b1;
                        state_in = S_RD_WAIT;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = 1'b1;
                        rsp_pixel_in  = '0;
                     end
                  end
               endcase
            end
         end
         S_FILL: begin
            op_we_in    = 1'b1;
            op_x_in     = bx_ff + COORD_W'(i_ff);
            op_y_in     = by_ff + COORD_W'(j_ff);
            op_color_in = fc_ff;
            if (i_ff == size_last) begin
               i_in = '0;
               if (j_ff == size_last) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = 1'b0;
                  rsp_pixel_in  = '0;
                  state_in      = S_IDLE;
               end else begin
                  j_in = j_ff + SIZE_W'(1);
               end
            end else begin
               i_in = i_ff + SIZE_W'(1);
            end
         end
         S_BOX: begin
            op_we_in    = 1'b1;
            op_color_in = box_color;
            unique case (phase_ff)
               2'd0: begin
                  op_x_in = cnt_ff;
                  op_y_in = by_ff;
               end
               2'd1: begin
                  op_x_in = cnt_ff;
                  op_y_in = ey_ff;
               end
               2'd2: begin
                  op_x_in = bx_ff;
                  op_y_in = cnt_ff;
               end
               default: begin
                  op_x_in = ex_ff;
                  op_y_in = cnt_ff;
               end
            endcase
            if (box_last) begin
               unique case (phase_ff)
                  2'd0: begin
                     phase_in = 2'd1;
                     cnt_in   = bx_ff;
                  end
                  2'd1: begin
                     phase_in = 2'd2;
                     cnt_in   = by_ff;
                  end
                  2'd2: begin
                     phase_in = 2'd3;
                     cnt_in   = by_ff;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = 1'b0;
                     rsp_pixel_in  = '0;
                     state_in      = S_IDLE;
                  end
               endcase
            end else begin
               cnt_in = cnt_ff + COORD_W'(1);
            end
         end
         S_RD_WAIT: begin
            state_in = S_RD_DONE;
         end
         S_RD_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = 1'b0;
            rsp_pixel_in  = ram_rdata;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_we_ff     <= 1'b0;
         op_re_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_we_ff     <= op_we_in;
         op_re_ff     <= op_re_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bx_ff         <= bx_in;
      by_ff         <= by_in;
      ex_ff         <= ex_in;
      ey_ff         <= ey_in;
      fc_ff         <= fc_in;
      size_ff       <= size_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      phase_ff      <= phase_in;
      cnt_ff        <= cnt_in;
      op_x_ff       <= op_x_in;
      op_y_ff       <= op_y_in;
      op_color_ff   <= op_color_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pixel_ff  <= rsp_pixel_in;
   end

   // Row-major address from the registered coordinates.
   assign lin       = PROD_W'(op_y_ff) * PROD_W'(WIDTH) + PROD_W'(op_x_ff);
   assign ram_addr  = lin[ADDR_W-1:0];
   assign ram_we    = op_we_ff;
   assign ram_re    = op_re_ff;
   assign ram_wdata = op_color_ff;

   assign busy = (state_ff != S_IDLE);
   assign rsp  = '{valid: rsp_valid_ff, status: rsp_status_ff, pixel: rsp_pixel_ff};

`ifndef ASSERT_OFF
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("response word raised while a command is still running");

   a_single_access: assert property (@(posedge clock) disable iff (reset)
      !(op_we_ff && op_re_ff))
      else $error("frame store written and read in the same cycle");

   a_write_in_frame: assert property (@(posedge clock) disable iff (reset)
      op_we_ff |-> ((op_x_ff < W_C) && (op_y_ff < H_C)))
      else $error("pixel write outside the frame");

   a_fill_counters: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> ((i_ff < size_ff) && (j_ff < size_ff)))
      else $error("fill counters past the square side");

   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD_WAIT) |=> (state_ff == S_RD_DONE))
      else $error("read-back did not wait exactly one cycle");
`endif

endmodule

>>> rtl/rgb565_framebuffer_draw_engine_top.sv
// Top level of the RGB565 framebuffer draw engine: ports, box colour register, sequencer, store.
`timescale 1ns / 1ps

// Draw engine over a WIDTH by HEIGHT RGB565 frame held in one on-chip
// single-port memory, row-major at y*WIDTH+x. A command word is taken at a
// rising edge with start high and busy low, and every command returns exactly
// one result word on rsp_status/rsp_pixel, marked by rsp_valid for a single
// cycle. The receiver cannot stall: capture the word in the cycle it is shown.
// Per command, from acceptance to the next possible acceptance: a pixel
// write, any rejected command and a square of size zero leave busy low, so
// such commands may follow back to back; a read-back passes through the
// address register, the memory read and the result register; a square fill
// or an outline keeps busy high while it walks its pixels, one pixel written
// per cycle through the memory's single write port.
// The result of a drawing command is shown in the same cycle as its last
// pixel write is presented to the store. The frame store is not cleared at
// reset; a pixel read before it was ever written returns an arbitrary value.
// box_color is written through the csr_ port (always ready) and resets to
// 0xE0FF; write it only while the engine is idle.

module rgb565_framebuffer_draw_engine_top
   import rfde_pkg::*;
#(
   parameter int WIDTH  = DEF_WIDTH,
   parameter int HEIGHT = DEF_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic [COORD_W-1:0] req_x0,
   input  logic [COORD_W-1:0] req_y0,
   input  logic [COORD_W-1:0] req_x1,
   input  logic [COORD_W-1:0] req_y1,
   input  logic [CHAN_W-1:0]  req_red,
   input  logic [CHAN_W-1:0]  req_green,
   input  logic [CHAN_W-1:0]  req_blue,
   input  logic [COLOR_W-1:0] req_fill_color,
   input  logic [SIZE_W-1:0]  req_size,

   output logic               rsp_valid,
   output logic               rsp_status,
   output logic [COLOR_W-1:0] rsp_pixel,

   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COLOR_W-1:0] csr_data
);

   // Frame geometry fixes the depth and address width of the store.
   localparam int DEPTH  = WIDTH * HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [COLOR_W-1:0] box_color_ff, box_color_in;
   req_type            req;
   rsp_type            rsp;
   logic               ram_we, ram_re;
   logic [ADDR_W-1:0]  ram_addr;
   logic [COLOR_W-1:0] ram_wdata, ram_rdata;

   // The register write never waits.
   assign csr_ready    = 1'b1;
   assign box_color_in = csr_valid ? csr_data : box_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_color_ff <= BOX_COLOR_RESET;
      end else begin
         box_color_ff <= box_color_in;
      end
   end

   // Gather the command word into one bundle for the sequencer.
   assign req = '{cmd:        req_cmd,
                  x0:         req_x0,
                  y0:         req_y0,
                  x1:         req_x1,
                  y1:         req_y1,
                  red:        req_red,
                  green:      req_green,
                  blue:       req_blue,
                  fill_color: req_fill_color,
                  size:       req_size};

   // Sequencer: checks each command on acceptance, then walks the pixels
   // of a square or outline one per cycle, or issues the read-back.
   rfde_draw_seq #(
      .WIDTH  (WIDTH),
      .HEIGHT (HEIGHT),
      .ADDR_W (ADDR_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req),
      .box_color (box_color_ff),
      .busy      (busy),
      .ram_we    (ram_we),
      .ram_re    (ram_re),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata),
      .rsp       (rsp)
   );

   // Frame store: one access per cycle, with registered read data.
   rfde_frame_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Drive the result word straight from the sequencer's output register.
   assign rsp_valid  = rsp.valid;
   assign rsp_status = rsp.status;
   assign rsp_pixel  = rsp.pixel;

endmodule

>>> tb/sv/tb_top.sv
// Self-checking bench for the RGB565 draw engine: directed table, then random commands.
`timescale 1ns / 1ps

module tb_top;
   import rfde_pkg::*;

   localparam int FRAME_W        = DEF_WIDTH;
   localparam int FRAME_H        = DEF_HEIGHT;
   localparam int PIXELS         = FRAME_W * FRAME_H;
   localparam int N_DIRECTED     = 25;
   localparam int N_PHASES       = 5;
   localparam int PHASE_ITEMS    = 200;
   localparam int RECENT_MAX     = 2048;
   // The limit leaves ample room for a full-frame outline.
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic               status;
      logic [COLOR_W-1:0] pixel;
   } result_type;

   // One row of the directed table: the command word and, where it is
   // obvious, the result typed in by hand.
   typedef struct packed {
      req_type    c;
      logic       typed;
      result_type want;
   } plan_row_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               start          = 1'b0;
   logic               busy;
   logic [1:0]         req_cmd        = CMD_PIXEL;
   logic [COORD_W-1:0] req_x0         = '0;
   logic [COORD_W-1:0] req_y0         = '0;
   logic [COORD_W-1:0] req_x1         = '0;
   logic [COORD_W-1:0] req_y1         = '0;
   logic [CHAN_W-1:0]  req_red        = '0;
   logic [CHAN_W-1:0]  req_green      = '0;
   logic [CHAN_W-1:0]  req_blue       = '0;
   logic [COLOR_W-1:0] req_fill_color = '0;
   logic [SIZE_W-1:0]  req_size       = '0;
   logic               rsp_valid;
   logic               rsp_status;
   logic [COLOR_W-1:0] rsp_pixel;
   logic               csr_valid      = 1'b0;
   logic               csr_ready;
   logic [COLOR_W-1:0] csr_data       = '0;

   // Shadow of the frame, which pixels hold a defined value, and a list of
   // recently painted pixels to aim read-backs at.
   logic [COLOR_W-1:0] frame_copy [PIXELS];
   bit                 painted    [PIXELS];
   int unsigned        recent_px  [$];
   logic [COLOR_W-1:0] box_colour_copy = BOX_COLOR_RESET;

   result_type         pending_q  [$];
   int                 fail_count   = 0;
   int                 quiet_cycles = 0;

   always #4 clock = ~clock;

   rgb565_framebuffer_draw_engine_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_x0         (req_x0),
      .req_y0         (req_y0),
      .req_x1         (req_x1),
      .req_y1         (req_y1),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_fill_color (req_fill_color),
      .req_size       (req_size),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_pixel      (rsp_pixel),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   // ---------------------------------------------------------------------
   // Frame shadow and draw predictor
   // ---------------------------------------------------------------------

   function automatic void paint(int x, int y, logic [COLOR_W-1:0] colour);
      int unsigned idx;
      int unsigned dropped;
      idx = y * FRAME_W + x;
      frame_copy[idx] = colour;
      painted[idx] = 1'b1;
      recent_px.push_back(idx);
      if (recent_px.size() > RECENT_MAX) dropped = recent_px.pop_front();
   endfunction

   // Apply one command word to the shadow frame and return its result word.
   function automatic result_type draw_predict(req_type c);
      result_type r;
      int x0, y0, x1, y1, sz;
      bit on_frame;
      x0 = int'(c.x0);
      y0 = int'(c.y0);
      x1 = int'(c.x1);
      y1 = int'(c.y1);
      sz = int'(c.size);
      r = '0;
      on_frame = (x0 < FRAME_W) && (y0 < FRAME_H);
      case (c.cmd)
         CMD_PIXEL: begin
            // keep the top 5/6/5 bits of each channel
            if (on_frame) paint(x0, y0, {c.red[7:3], c.green[7:2], c.blue[7:3]});
            else r.status = 1'b1;
         end
         CMD_FILL: begin
            // a zero-sized square paints nothing but still takes the edge test
            if (x0 + sz > FRAME_W || y0 + sz > FRAME_H) begin
               r.status = 1'b1;
            end else begin
               for (int j = 0; j < sz; j++)
                  for (int i = 0; i < sz; i++) paint(x0 + i, y0 + j, c.fill_color);
            end
         end
         CMD_BOX: begin
            if (x0 >= FRAME_W || x1 >= FRAME_W || y0 >= FRAME_H || y1 >= FRAME_H ||
                x0 > x1 || y0 > y1) begin
               r.status = 1'b1;
            end else begin
               for (int i = x0; i <= x1; i++) begin
                  paint(i, y0, box_colour_copy);
                  paint(i, y1, box_colour_copy);
               end
               for (int j = y0; j <= y1; j++) begin
                  paint(x0, j, box_colour_copy);
                  paint(x1, j, box_colour_copy);
               end
            end
         end
         CMD_READ: begin
            if (on_frame) r.pixel = frame_copy[y0 * FRAME_W + x0];
            else r.status = 1'b1;
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic req_type mk(logic [1:0] cmd, int x0, int y0, int x1, int y1,
                                  logic [23:0] rgb, logic [COLOR_W-1:0] fc, int sz);
      req_type c;
      c.cmd        = cmd;
      c.x0         = COORD_W'(x0);
      c.y0         = COORD_W'(y0);
      c.x1         = COORD_W'(x1);
      c.y1         = COORD_W'(y1);
      c.red        = rgb[23:16];
      c.green      = rgb[15:8];
      c.blue       = rgb[7:0];
      c.fill_color = fc;
      c.size       = SIZE_W'(sz);
      return c;
   endfunction

   function automatic plan_row_type plan_row(req_type c, logic typed, logic st,
                                             logic [COLOR_W-1:0] px);
      plan_row_type r;
      r.c           = c;
      r.typed       = typed;
      r.want.status = st;
      r.want.pixel  = px;
      return r;
   endfunction

   // Bias coordinates towards a small corner patch (so read-backs find
   // painted pixels), the frame edge, anywhere on the frame, or anywhere.
   function automatic logic [COORD_W-1:0] pick_coord(int lim);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return COORD_W'($urandom_range(0, 23));
         4, 5:       return COORD_W'($urandom_range(lim - 16, lim + 1));
         6, 7:       return COORD_W'($urandom_range(0, lim - 1));
         default:    return COORD_W'($urandom_range(0, 1023));
      endcase
   endfunction

   function automatic req_type gen_random_cmd();
      req_type     c;
      int unsigned roll;
      int unsigned idx;
      int          lo;
      c.cmd        = CMD_READ;
      c.x0         = COORD_W'($urandom_range(0, 1023));
      c.y0         = COORD_W'($urandom_range(0, 1023));
      c.x1         = COORD_W'($urandom_range(0, 1023));
      c.y1         = COORD_W'($urandom_range(0, 1023));
      c.red        = CHAN_W'($urandom_range(0, 255));
      c.green      = CHAN_W'($urandom_range(0, 255));
      c.blue       = CHAN_W'($urandom_range(0, 255));
      c.fill_color = COLOR_W'($urandom_range(0, 65535));
      c.size       = SIZE_W'($urandom_range(0, 15));
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         c.cmd = CMD_PIXEL;
         c.x0  = pick_coord(FRAME_W);
         c.y0  = pick_coord(FRAME_H);
      end else if (roll < 50) begin
         c.cmd = CMD_FILL;
         c.x0  = pick_coord(FRAME_W);
         c.y0  = pick_coord(FRAME_H);
      end else if (roll < 65) begin
         c.cmd = CMD_BOX;
         roll = $urandom_range(0, 19);
         if (roll == 0) begin
            // near full-frame outline: slow, so keep it rare
            c.x0 = COORD_W'($urandom_range(0, 15));
            c.y0 = COORD_W'($urandom_range(0, 15));
            c.x1 = COORD_W'($urandom_range(FRAME_W - 16, FRAME_W - 1));
            c.y1 = COORD_W'($urandom_range(FRAME_H - 16, FRAME_H - 1));
         end else if (roll == 3) begin
            // inverted corners on one axis
            lo = $urandom_range(1, FRAME_W - 1);
            c.x0 = COORD_W'(lo);
            c.x1 = COORD_W'($urandom_range(0, lo - 1));
            c.y0 = COORD_W'($urandom_range(0, 23));
            c.y1 = c.y0 + COORD_W'($urandom_range(0, 7));
         end else if (roll > 3) begin
            // small outline; an edge start may overrun and get rejected
            c.x0 = pick_coord(FRAME_W);
            c.y0 = pick_coord(FRAME_H);
            c.x1 = c.x0 + COORD_W'($urandom_range(0, 7));
            c.y1 = c.y0 + COORD_W'($urandom_range(0, 7));
         end
         // otherwise keep the fully random corners, mostly rejected
      end else begin
         c.cmd = CMD_READ;
         if (recent_px.size() != 0 && $urandom_range(0, 3) != 0) begin
            idx  = recent_px[$urandom_range(0, recent_px.size() - 1)];
            c.x0 = COORD_W'(idx % FRAME_W);
            c.y0 = COORD_W'(idx / FRAME_W);
         end else begin
            c.x0 = pick_coord(FRAME_W);
            c.y0 = pick_coord(FRAME_H);
            // never read an unpainted pixel: steer such a read off the frame
            if (int'(c.x0) < FRAME_W && int'(c.y0) < FRAME_H &&
                !painted[int'(c.y0) * FRAME_W + int'(c.x0)])
               c.x0 = COORD_W'($urandom_range(FRAME_W, 1023));
         end
      end
      return c;
   endfunction

   // ---------------------------------------------------------------------
   // Command and register drivers
   // ---------------------------------------------------------------------

   // Present a command word, hold it until taken, then log its expected result.
   // Start is left high so the next word can follow back to back.
   task automatic issue(input req_type c, input logic typed, input result_type want);
      result_type got;
      req_cmd        <= c.cmd;
      req_x0         <= c.x0;
      req_y0         <= c.y0;
      req_x1         <= c.x1;
      req_y1         <= c.y1;
      req_red        <= c.red;
      req_green      <= c.green;
      req_blue       <= c.blue;
      req_fill_color <= c.fill_color;
      req_size       <= c.size;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      got = draw_predict(c);
      pending_q.push_back(typed ? want : got);
   endtask

   task automatic pause_sender(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Drop start and hold off until every result word is back.
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_box_colour(input logic [COLOR_W-1:0] colour);
      csr_data  <= colour;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      box_colour_copy = colour;
      csr_valid <= 1'b0;
   endtask

   task automatic log_mismatch(input string what, input result_type want,
                               input result_type seen);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t %s: expected status %0d pixel %04h, got status %0d pixel %04h",
                  $realtime, what, want.status, want.pixel, seen.status, seen.pixel);
   endtask

   // ---------------------------------------------------------------------
   // Result checker: every rsp_valid cycle carries one word, compare it
   // with the oldest expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      result_type want;
      result_type seen;
      if (!reset && rsp_valid) begin
         seen.status = rsp_status;
         seen.pixel  = rsp_pixel;
         if (pending_q.size() == 0) begin
            log_mismatch("result word with nothing pending", '0, seen);
         end else begin
            want = pending_q.pop_front();
            if (seen.status !== want.status || seen.pixel !== want.pixel)
               log_mismatch("result word mismatch", want, seen);
         end
      end
   end

   // Watchdog: count cycles in which no word moves on any channel.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : run
      plan_row_type       plan    [N_DIRECTED];
      logic [COLOR_W-1:0] colours [N_PHASES];
      bit                 gaps_on;
      bit                 last_phase;

      // Directed table: frame corners, every off-frame test, both square
      // edges, zero-sized squares, the full-frame outline in the reset colour,
      // inverted and overrunning boxes, and a single-pixel box.
      plan[0]  = plan_row(mk(CMD_PIXEL,    0,    0,   0,   0, 24'hFFFFFF, 16'h0,  0),
                          1'b1, 1'b0, 16'h0000);
      plan[1]  = plan_row(mk(CMD_READ,     0,    0,   0,   0, 24'h0, 16'h0,  0),
                          1'b1, 1'b0, 16'hFFFF);
      plan[2]  = plan_row(mk(CMD_PIXEL,  319,  239,   0,   0, 24'h000000, 16'h0,  0),
                          1'b1, 1'b0, 16'h0000);
      plan[3]  = plan_row(mk(CMD_READ,   319,  239,   0,   0, 24'h0, 16'h0,  0),
                          1'b1, 1'b0, 16'h0000);
      plan[4]  = plan_row(mk(CMD_PIXEL,  320,    0,   0,   0, 24'h123456, 16'h0,  0),
                          1'b1, 1'b1, 16'h0000);
      plan[5]  = plan_row(mk(CMD_PIXEL,    0,  240,   0,   0, 24'h123456, 16'h0,  0),
                          1'b1, 1'b1, 16'h0000);
      plan[6]  = plan_row(mk(CMD_PIXEL, 1023, 1023,   0,   0, 24'h5A5A5A, 16'h0,  0),
                          1'b1, 1'b1, 16'h0000);
      plan[7]  = plan_row(mk(CMD_READ,  1023,    5,   0,   0, 24'h0, 16'h0,  0),
                          1'b1, 1'b1, 16'h0000);
      plan[8]  = plan_row(mk(CMD_READ,     5,  240,   0,   0, 24'h0, 16'h0,  0),
                          1'b1, 1'b1, 16'h0000);
      plan[9]  = plan_row(mk(CMD_PIXEL,    1,    1,   0,   0, 24'h874321, 16'h0,  0),
                          1'b0, 1'b0, 16'h0000);
      plan[10] = plan_row(mk(CMD_READ,     1,    1,   0,   0, 24'h0, 16'h0,  0),
                          1'b0, 1'b0, 16'h0000);
      plan[11] = plan_row(mk(CMD_FILL,    10,   10,   0,   0, 24'h0, 16'h1234, 15),
                          1'b0, 1'b0, 16'h0000);
      plan[12] = plan_row(mk(CMD_READ,    24,   24,   0,   0, 24'h0, 16'h0,  0),
                          1'b0, 1'b0, 16'h0000);
      plan[13] = plan_row(mk(CMD_FILL,   305,    0,   0,   0, 24'h0, 16'hABCD, 15),
                          1'b0, 1'b0, 16'h0000);
      plan[14] = plan_row(mk(CMD_FILL,   306,    0,   0,   0, 24'h0, 16'hFFFF, 15),
                          1'b1, 1'b1, 16'h0000);
      plan[15] = plan_row(mk(CMD_FILL,     0,  226,   0,   0, 24'h0, 16'hFFFF, 15),
                          1'b1, 1'b1, 16'h0000);
      plan[16] = plan_row(mk(CMD_FILL,   320,    0,   0,   0, 24'h0, 16'h5555,  0),
                          1'b0, 1'b0, 16'h0000);
      plan[17] = plan_row(mk(CMD_FILL,   321,    5,   0,   0, 24'h0, 16'h5555,  0),
                          1'b1, 1'b1, 16'h0000);
      plan[18] = plan_row(mk(CMD_BOX,      0,    0, 319, 239, 24'h0, 16'h0,  0),
                          1'b0, 1'b0, 16'h0000);
      plan[19] = plan_row(mk(CMD_READ,   319,  100,   0,   0, 24'h0, 16'h0,  0),
                          1'b1, 1'b0, BOX_COLOR_RESET);
      plan[20] = plan_row(mk(CMD_BOX,      5,    5,   4,   8, 24'h0, 16'h0,  0),
                          1'b1, 1'b1, 16'h0000);
      plan[21] = plan_row(mk(CMD_BOX,      5,    9,   6,   8, 24'h0, 16'h0,  0),
                          1'b1, 1'b1, 16'h0000);
      plan[22] = plan_row(mk(CMD_BOX,      0,    0, 320,  10, 24'h0, 16'h0,  0),
                          1'b1, 1'b1, 16'h0000);
      plan[23] = plan_row(mk(CMD_BOX,      0,    0,  10, 240, 24'h0, 16'h0,  0),
                          1'b1, 1'b1, 16'h0000);
      plan[24] = plan_row(mk(CMD_BOX,     50,   50,  50,  50, 24'h0, 16'h0,  0),
                          1'b0, 1'b0, 16'h0000);

      // Outline colour per random phase: both extremes, then random values.
      colours[0] = 16'h0000;
      colours[1] = 16'hFFFF;
      for (int p = 2; p < N_PHASES; p++) colours[p] = COLOR_W'($urandom_range(0, 65535));

      // Hold reset, then release it for good.
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part runs with the reset outline colour.
      foreach (plan[k]) begin
         issue(plan[k].c, plan[k].typed, plan[k].want);
         if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 11));
      end

      // Random phases; change the outline colour only with the engine idle.
      // The last phase runs with no gaps at all.
      for (int p = 0; p < N_PHASES; p++) begin
         last_phase = (p == N_PHASES - 1);
         wait_drained();
         write_box_colour(colours[p]);
         gaps_on = 1'b0;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // alternate stretches with and without sender gaps
            if (k % 40 == 0) gaps_on = !last_phase && ($urandom_range(0, 2) != 0);
            issue(gen_random_cmd(), 1'b0, '0);
            if (gaps_on && $urandom_range(0, 2) == 0)
               pause_sender($urandom_range(1, 11));
            else if (!last_phase && $urandom_range(0, 49) == 0)
               wait_drained();
         end
      end

      // Let the last result words come back, then allow a short tail for
      // anything spurious.
      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (fail_count == 0 && pending_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
